// ----- hdl/pflc_pkg.sv -----
// Package: widths, codes and reset values for the PIN and fob lock controller.
`default_nettype none
package pflc_pkg;

  localparam int PIN_DIGITS = 4;
  localparam int FOB_SLOTS  = 8;

  localparam int PIN_POS_W = $clog2(PIN_DIGITS + 1);
  localparam int PIN_IDX_W = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
  localparam int FOB_CNT_W = $clog2(FOB_SLOTS + 1);
  localparam int FOB_IDX_W = (FOB_SLOTS > 1) ? $clog2(FOB_SLOTS) : 1;

  localparam int REQ_W   = 3;
  localparam int DIGIT_W = 4;
  localparam int UID_W   = 32;
  localparam int MODE_W  = 3;
  localparam int EVENT_W = 4;
  localparam int COUNT_W = 4;
  localparam int POS_W   = 3;

  localparam logic [REQ_W-1:0] REQ_DIGIT   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FOB     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TOGGLE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PROGRAM = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CHPIN   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CANCEL  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd6;

  localparam logic [MODE_W-1:0] MODE_LOCKED   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UNLOCKED = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PROGRAM  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CHANGE1  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CHANGE2  = 3'd4;

  localparam logic [EVENT_W-1:0] EV_NONE        = 4'd0;
  localparam logic [EVENT_W-1:0] EV_UNLOCKED    = 4'd1;
  localparam logic [EVENT_W-1:0] EV_LOCKED      = 4'd2;
  localparam logic [EVENT_W-1:0] EV_WRONG_PIN   = 4'd3;
  localparam logic [EVENT_W-1:0] EV_UNKNOWN_FOB = 4'd4;
  localparam logic [EVENT_W-1:0] EV_FOB_STORED  = 4'd5;
  localparam logic [EVENT_W-1:0] EV_TABLE_FULL  = 4'd6;
  localparam logic [EVENT_W-1:0] EV_FIRST_PASS  = 4'd7;
  localparam logic [EVENT_W-1:0] EV_PIN_CHANGED = 4'd8;
  localparam logic [EVENT_W-1:0] EV_MISMATCH    = 4'd9;
  localparam logic [EVENT_W-1:0] EV_IGNORED     = 4'd10;

  typedef logic [PIN_DIGITS-1:0][DIGIT_W-1:0] pin_t;

  function automatic pin_t pin_reset();
    pin_t p;
    for (int i = 0; i < PIN_DIGITS; i++) begin
      p[i] = DIGIT_W'(i + 1);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/pflc_req_if.sv -----
// Interface: request channel carrying one keypad or fob event.
`default_nettype none
interface pflc_req_if;
  logic                         valid;
  logic                         ready;
  logic [pflc_pkg::REQ_W-1:0]   req_type;
  logic [pflc_pkg::DIGIT_W-1:0] digit;
  logic [pflc_pkg::UID_W-1:0]   fob_uid;

  modport source (output valid, req_type, digit, fob_uid, input ready);
  modport sink   (input valid, req_type, digit, fob_uid, output ready);
endinterface
`default_nettype wire

// ----- hdl/pflc_rsp_if.sv -----
// Interface: result channel carrying mode, event and counts.
`default_nettype none
interface pflc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [pflc_pkg::MODE_W-1:0]  mode_now;
  logic [pflc_pkg::EVENT_W-1:0] event_code;
  logic                         drive_inhibit;
  logic [pflc_pkg::COUNT_W-1:0] fob_count_now;
  logic [pflc_pkg::POS_W-1:0]   digits_entered;

  modport source (output valid, mode_now, event_code, drive_inhibit, fob_count_now,
                  digits_entered, input ready);
  modport sink   (input valid, mode_now, event_code, drive_inhibit, fob_count_now,
                  digits_entered, output ready);
endinterface
`default_nettype wire

// ----- hdl/pin_and_fob_lock_controller.sv -----
// Top level: keypad and fob lock controller with fob table in a synchronous RAM.
//
//  port    dir  handshake     carries
//  req_i   in   valid/ready   req_type, digit, fob_uid
//  rsp_o   out  valid/ready   mode_now, event_code, drive_inhibit, fob_count_now,
//                             digits_entered
//  cfg     in   cfg_we_i      cfg_wdata_i -> lock_enabled
//
// A fob tap with fobs stored, lock on, in locked, unlocked or program mode walks the
// fob RAM one entry per cycle (registered read) to a match or the last entry.
// One request in flight; req_i.ready is high while the sequencer is idle, also when
// a finished result still waits in the output register.
// Reset clears mode, entry, first pass, count and restores PIN 1,2,3,4; the fob RAM
// needs no clearing since only entries below the fob count are read.
`default_nettype none
module pin_and_fob_lock_controller (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i,
  pflc_req_if.sink   req_i,
  pflc_rsp_if.source rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_q, state_d;

  logic lock_en_q;
  logic [pflc_pkg::MODE_W-1:0]    mode_q, mode_d;
  logic [pflc_pkg::PIN_POS_W-1:0] pos_q, pos_d;
  pflc_pkg::pin_t                 entry_q, entry_d;
  pflc_pkg::pin_t                 first_q, first_d;
  pflc_pkg::pin_t                 pin_q, pin_d;
  logic [pflc_pkg::FOB_CNT_W-1:0] cnt_q, cnt_d;

  logic [pflc_pkg::REQ_W-1:0]     req_q;
  logic [pflc_pkg::DIGIT_W-1:0]   digit_q;
  logic [pflc_pkg::UID_W-1:0]     uid_q;
  logic [pflc_pkg::FOB_IDX_W-1:0] idx_q;
  logic                           hit_q;

  logic [pflc_pkg::UID_W-1:0]     mem [pflc_pkg::FOB_SLOTS];
  logic [pflc_pkg::UID_W-1:0]     rdata_q;
  logic [pflc_pkg::FOB_IDX_W-1:0] rd_addr;
  logic                           wr_en;

  logic                           out_valid_q;
  logic [pflc_pkg::MODE_W-1:0]    out_mode_q;
  logic [pflc_pkg::EVENT_W-1:0]   out_ev_q;
  logic [pflc_pkg::COUNT_W-1:0]   out_cnt_q;
  logic [pflc_pkg::POS_W-1:0]     out_pos_q;

  logic accept, fire, need_scan, match, last;
  logic [pflc_pkg::EVENT_W-1:0]   ev;
  logic [pflc_pkg::PIN_POS_W-1:0] pos_new;
  pflc_pkg::pin_t                 entry_new;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign fire        = (state_q == S_EMIT) && (!out_valid_q || rsp_o.ready);

  assign need_scan = (req_i.req_type == pflc_pkg::REQ_FOB) && lock_en_q && (cnt_q != '0)
                     && ((mode_q == pflc_pkg::MODE_LOCKED) || (mode_q == pflc_pkg::MODE_UNLOCKED)
                         || (mode_q == pflc_pkg::MODE_PROGRAM));

  assign match   = (rdata_q == uid_q);
  assign last    = ((pflc_pkg::FOB_CNT_W'(idx_q) + 1'b1) == cnt_q);
  assign rd_addr = (state_q == S_SCAN) ? idx_q + 1'b1 : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = need_scan ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        if (match || last) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    entry_d   = entry_q;
    first_d   = first_q;
    pin_d     = pin_q;
    cnt_d     = cnt_q;
    wr_en     = 1'b0;
    ev        = pflc_pkg::EV_NONE;
    pos_new   = pos_q + 1'b1;
    entry_new = entry_q;
    if (pos_q < pflc_pkg::PIN_POS_W'(pflc_pkg::PIN_DIGITS)) begin
      entry_new[pos_q[pflc_pkg::PIN_IDX_W-1:0]] = digit_q;
    end
    case (req_q)
      pflc_pkg::REQ_DIGIT: begin
        if (pos_q >= pflc_pkg::PIN_POS_W'(pflc_pkg::PIN_DIGITS)) begin
          ev = pflc_pkg::EV_IGNORED;
        end else if (pos_new < pflc_pkg::PIN_POS_W'(pflc_pkg::PIN_DIGITS)) begin
          entry_d = entry_new;
          pos_d   = pos_new;
        end else begin
          case (mode_q)
            pflc_pkg::MODE_LOCKED: begin
              entry_d = '0;
              pos_d   = '0;
              if (entry_new == pin_q) begin
                mode_d = pflc_pkg::MODE_UNLOCKED;
                ev     = pflc_pkg::EV_UNLOCKED;
              end else begin
                ev = pflc_pkg::EV_WRONG_PIN;
              end
            end
            pflc_pkg::MODE_CHANGE1: begin
              first_d = entry_new;
              entry_d = '0;
              pos_d   = '0;
              mode_d  = pflc_pkg::MODE_CHANGE2;
              ev      = pflc_pkg::EV_FIRST_PASS;
            end
            pflc_pkg::MODE_CHANGE2: begin
              if (entry_new == first_q) begin
                pin_d = first_q;
                ev    = pflc_pkg::EV_PIN_CHANGED;
              end else begin
                ev = pflc_pkg::EV_MISMATCH;
              end
              entry_d = '0;
              pos_d   = '0;
              first_d = '0;
              mode_d  = pflc_pkg::MODE_UNLOCKED;
            end
            default: begin
              entry_d = entry_new;
              pos_d   = pos_new;
            end
          endcase
        end
      end
      pflc_pkg::REQ_FOB: begin
        if (!lock_en_q) begin
          ev = pflc_pkg::EV_IGNORED;
        end else begin
          case (mode_q)
            pflc_pkg::MODE_PROGRAM: begin
              mode_d = pflc_pkg::MODE_LOCKED;
              if (hit_q) begin
                ev = pflc_pkg::EV_FOB_STORED;
              end else if (cnt_q >= pflc_pkg::FOB_CNT_W'(pflc_pkg::FOB_SLOTS)) begin
                ev = pflc_pkg::EV_TABLE_FULL;
              end else begin
                wr_en = 1'b1;
                cnt_d = cnt_q + 1'b1;
                ev    = pflc_pkg::EV_FOB_STORED;
              end
            end
            pflc_pkg::MODE_LOCKED: begin
              if (hit_q) begin
                mode_d  = pflc_pkg::MODE_UNLOCKED;
                entry_d = '0;
                pos_d   = '0;
                ev      = pflc_pkg::EV_UNLOCKED;
              end else begin
                ev = pflc_pkg::EV_UNKNOWN_FOB;
              end
            end
            pflc_pkg::MODE_UNLOCKED: begin
              if (hit_q) begin
                mode_d  = pflc_pkg::MODE_LOCKED;
                entry_d = '0;
                pos_d   = '0;
                ev      = pflc_pkg::EV_LOCKED;
              end
            end
            default: ev = pflc_pkg::EV_IGNORED;
          endcase
        end
      end
      pflc_pkg::REQ_TOGGLE: begin
        if (mode_q == pflc_pkg::MODE_UNLOCKED) begin
          mode_d = pflc_pkg::MODE_LOCKED;
          ev     = pflc_pkg::EV_LOCKED;
        end else begin
          mode_d = pflc_pkg::MODE_UNLOCKED;
          ev     = pflc_pkg::EV_UNLOCKED;
        end
        entry_d = '0;
        pos_d   = '0;
      end
      pflc_pkg::REQ_PROGRAM: begin
        if (mode_q == pflc_pkg::MODE_UNLOCKED) mode_d = pflc_pkg::MODE_PROGRAM;
        else ev = pflc_pkg::EV_IGNORED;
      end
      pflc_pkg::REQ_CHPIN: begin
        if (mode_q == pflc_pkg::MODE_UNLOCKED) begin
          mode_d  = pflc_pkg::MODE_CHANGE1;
          entry_d = '0;
          pos_d   = '0;
          first_d = '0;
        end else begin
          ev = pflc_pkg::EV_IGNORED;
        end
      end
      pflc_pkg::REQ_CANCEL: begin
        if (mode_q == pflc_pkg::MODE_UNLOCKED) begin
          ev = pflc_pkg::EV_IGNORED;
        end else begin
          mode_d  = pflc_pkg::MODE_LOCKED;
          entry_d = '0;
          pos_d   = '0;
          first_d = '0;
        end
      end
      pflc_pkg::REQ_CLEAR: cnt_d = '0;
      default: ev = pflc_pkg::EV_IGNORED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lock_en_q   <= 1'b1;
      mode_q      <= pflc_pkg::MODE_LOCKED;
      pos_q       <= '0;
      entry_q     <= '0;
      first_q     <= '0;
      pin_q       <= pflc_pkg::pin_reset();
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) lock_en_q <= cfg_wdata_i;
      if (fire) begin
        mode_q  <= mode_d;
        pos_q   <= pos_d;
        entry_q <= entry_d;
        first_q <= first_d;
        pin_q   <= pin_d;
        cnt_q   <= cnt_d;
      end
      if (fire) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_i.req_type;
      digit_q <= req_i.digit;
      uid_q   <= req_i.fob_uid;
      idx_q   <= '0;
      hit_q   <= 1'b0;
    end else if (state_q == S_SCAN) begin
      if (match) hit_q <= 1'b1;
      idx_q <= idx_q + 1'b1;
    end
    if (fire) begin
      out_mode_q <= mode_d;
      out_ev_q   <= ev;
      out_cnt_q  <= pflc_pkg::COUNT_W'(cnt_d);
      out_pos_q  <= pflc_pkg::POS_W'(pos_d);
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[rd_addr];
    if (fire && wr_en) mem[cnt_q[pflc_pkg::FOB_IDX_W-1:0]] <= uid_q;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.mode_now       = out_mode_q;
  assign rsp_o.event_code     = out_ev_q;
  assign rsp_o.drive_inhibit  = (out_mode_q != pflc_pkg::MODE_UNLOCKED);
  assign rsp_o.fob_count_now  = out_cnt_q;
  assign rsp_o.digits_entered = out_pos_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pflc_pkg::FOB_CNT_W'(pflc_pkg::FOB_SLOTS))
    else $error("fob count exceeds table size");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= pflc_pkg::PIN_POS_W'(pflc_pkg::PIN_DIGITS))
    else $error("entry position exceeds PIN length");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (pflc_pkg::FOB_CNT_W'(idx_q) < cnt_q))
    else $error("fob scan beyond stored entries");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted request not processed");

  a_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && wr_en) |-> (cnt_q < pflc_pkg::FOB_CNT_W'(pflc_pkg::FOB_SLOTS)) && !hit_q)
    else $error("fob write into full table or for known fob");
`endif

endmodule
`default_nettype wire
